// ===== sv/hgwq_pkg.sv =====
`default_nettype none
package hgwq_pkg;

    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_RESET  = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    localparam logic [6:0] PCT_FULL = 7'd100;

    typedef enum logic [3:0] {
        K_SAMPLE = 4'b0001,
        K_RESET  = 4'b0010,
        K_QUERY  = 4'b0100,
        K_NOP    = 4'b1000
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [63:0] time_ns;
        logic [6:0]  pct;
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_SCAN = 3'b100
    } t_state;

endpackage
`default_nettype wire

// ===== sv/hgwq_ram.sv =====
`default_nettype none
module hgwq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  wire                       i_clk,
    input  wire                       i_we,
    input  wire [$clog2(DEPTH)-1:0]   i_waddr,
    input  wire [WIDTH-1:0]           i_wdata,
    input  wire [$clog2(DEPTH)-1:0]   i_raddr,
    output logic [WIDTH-1:0]          o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== sv/hgwq_div100.sv =====
`default_nettype none
module hgwq_div100
    import hgwq_pkg::*;
#(
    parameter int QW = 20
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_start,
    input  wire [QW-1:0]  i_num,
    output logic          o_done,
    output logic [QW-1:0] o_quot
);
    // Division by 100 as a multiply by the reciprocal, rounded up and scaled by
    // 2^(QW+7). The rounding error times any QW-bit numerator stays below one
    // unit of the shift, so the quotient is exact. The numerator is registered at the
    // start, and the quotient is then registered together with o_done.
    localparam int SH = QW + 7;
    localparam int PW = QW + SH;
    localparam logic [PW-1:0] RECIP =
        PW'(((64'd1 << SH) + 64'(PCT_FULL) - 64'd1) / 64'(PCT_FULL));

    logic [QW-1:0] r_num;
    logic          r_busy;
    logic [PW-1:0] w_prod;

    assign w_prod = PW'(r_num) * RECIP;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
        end
        if (r_busy) begin
            o_quot <= w_prod[PW-1:SH];
        end
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            r_busy <= i_start;
            o_done <= r_busy;
        end
    end
endmodule
`default_nettype wire

// ===== sv/hgwq_front.sv =====
`default_nettype none
module hgwq_front
    import hgwq_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire  [1:0]  i_operation,
    input  wire  [63:0] i_time_ns,
    input  wire  [6:0]  i_percent,
    output logic        o_cvalid,
    output t_cmd        o_cmd,
    input  wire         i_cpop
);
    // Decodes requests and holds them in a two-entry queue.
    t_cmd       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_cmd       w_cmd;
    logic       w_push;
    logic       w_pop;

    always_comb begin
        w_cmd.time_ns = i_time_ns;
        w_cmd.pct     = (i_percent > PCT_FULL) ? PCT_FULL : i_percent;
        unique case (i_operation)
            OP_SAMPLE: w_cmd.kind = K_SAMPLE;
            OP_RESET:  w_cmd.kind = K_RESET;
            OP_QUERY:  w_cmd.kind = K_QUERY;
            default:   w_cmd.kind = K_NOP;
        endcase
    end

    assign o_ready  = (r_cnt != 2'd2);
    assign w_push   = i_valid && o_ready;
    assign o_cvalid = (r_cnt != 2'd0);
    assign w_pop    = i_cpop && o_cvalid;
    assign o_cmd    = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end
endmodule
`default_nettype wire

// ===== sv/hgwq_back.sv =====
`default_nettype none
module hgwq_back
    import hgwq_pkg::*;
#(
    parameter int WINDOW = 4096
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cvalid,
    input  t_cmd        i_cmd,
    output logic        o_cpop,
    output logic        o_valid,
    input  wire         i_ready,
    output logic [63:0] o_gap_ns,
    output logic [63:0] o_quantile_ns,
    output logic [63:0] o_max_gap_ns,
    output logic [31:0] o_total_samples,
    output logic [12:0] o_window_samples
);
    localparam int AW = $clog2(WINDOW);
    localparam int CW = $clog2(WINDOW + 1);
    localparam int QW = CW + 7;

    t_state        r_state;
    logic [63:0]   r_last;
    logic [AW-1:0] r_slot;
    logic [31:0]   r_total;
    logic [63:0]   r_max;
    logic [CW-1:0] r_n;
    logic [CW-1:0] r_k;
    logic [CW-1:0] r_addr;
    logic [CW-1:0] r_cnt;
    logic          r_rvld;
    logic [5:0]    r_bit;
    logic [63:0]   r_prefix;

    logic [CW-1:0] w_vc;
    logic [31:0]   w_total_inc;
    logic [CW-1:0] w_vc_inc;
    logic [63:0]   w_gap;
    logic          w_slot_free;
    logic [63:0]   w_rdata;
    logic [63:0]   w_mask_hi;
    logic          w_match;
    logic          w_issue;
    logic          w_div_start;
    logic [QW-1:0] w_div_num;
    logic          w_div_done;
    logic [QW-1:0] w_div_quot;
    logic          w_we;
    logic [63:0]   w_prefix_nx;
    logic          w_fin;

    function automatic logic [CW-1:0] f_vc(input logic [31:0] total);
        f_vc = (total < 32'(WINDOW)) ? CW'(total) : CW'(WINDOW);
    endfunction

    assign w_vc        = f_vc(r_total);
    assign w_total_inc = (r_total == 32'hFFFF_FFFF) ? r_total : r_total + 32'd1;
    assign w_vc_inc    = f_vc(w_total_inc);
    assign w_gap       = i_cmd.time_ns - r_last;
    assign w_slot_free = !o_valid || i_ready;
    assign o_cpop      = (r_state == S_IDLE) && i_cvalid && w_slot_free;
    assign w_we        = o_cpop && (i_cmd.kind == K_SAMPLE);
    assign w_div_start = o_cpop && (i_cmd.kind == K_QUERY) && (w_vc != '0);
    assign w_div_num   = QW'(w_vc - 1'b1) * QW'(i_cmd.pct);
    assign w_issue     = (r_state == S_SCAN) && (r_addr != r_n);
    assign w_mask_hi   = ({64{1'b1}} << r_bit) << 1;
    assign w_match     = (((w_rdata ^ r_prefix) & w_mask_hi) == 64'd0) && !w_rdata[r_bit];
    // A result is ready when a request other than a non-empty query is taken,
    // or when the last bit of a selection has been fixed.
    assign w_fin       = (o_cpop && ((i_cmd.kind != K_QUERY) || (w_vc == '0)))
                      || ((r_state == S_SCAN) && !w_issue && !r_rvld && (r_bit == 6'd0));

    always_comb begin
        w_prefix_nx        = r_prefix;
        w_prefix_nx[r_bit] = !(r_k < r_cnt);
    end

    hgwq_ram #(.WIDTH(64), .DEPTH(WINDOW)) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_slot),
        .i_wdata (w_gap),
        .i_raddr (r_addr[AW-1:0]),
        .o_rdata (w_rdata)
    );

    hgwq_div100 #(.QW(QW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_last  <= 64'd0;
            r_slot  <= '0;
            r_total <= 32'd0;
            r_max   <= 64'd0;
            o_valid <= 1'b0;
            r_rvld  <= 1'b0;
        end else begin
            if (w_fin) begin
                o_valid <= 1'b1;
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
            r_rvld <= w_issue;
            unique case (r_state)
                S_IDLE: begin
                    if (o_cpop) begin
                        o_gap_ns      <= (i_cmd.kind == K_SAMPLE) ? w_gap : 64'd0;
                        o_quantile_ns <= 64'd0;
                        case (i_cmd.kind)
                            K_SAMPLE: begin
                                r_last  <= i_cmd.time_ns;
                                r_slot  <= (r_slot == AW'(WINDOW - 1)) ? '0 : r_slot + 1'b1;
                                r_total <= w_total_inc;
                                if (w_gap > r_max) begin
                                    r_max <= w_gap;
                                end
                                o_max_gap_ns     <= (w_gap > r_max) ? w_gap : r_max;
                                o_total_samples  <= w_total_inc;
                                o_window_samples <= 13'(w_vc_inc);
                            end
                            K_RESET: begin
                                r_last           <= i_cmd.time_ns;
                                r_slot           <= '0;
                                r_total          <= 32'd0;
                                r_max            <= 64'd0;
                                o_max_gap_ns     <= 64'd0;
                                o_total_samples  <= 32'd0;
                                o_window_samples <= 13'd0;
                            end
                            K_QUERY: begin
                                o_max_gap_ns     <= r_max;
                                o_total_samples  <= r_total;
                                o_window_samples <= 13'(w_vc);
                                r_n              <= w_vc;
                                if (w_vc != '0) begin
                                    r_state <= S_DIV;
                                end
                            end
                            default: begin
                                o_max_gap_ns     <= r_max;
                                o_total_samples  <= r_total;
                                o_window_samples <= 13'(w_vc);
                            end
                        endcase
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_k      <= w_div_quot[CW-1:0];
                        r_bit    <= 6'd63;
                        r_prefix <= 64'd0;
                        r_addr   <= '0;
                        r_cnt    <= '0;
                        r_state  <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (w_issue) begin
                        r_addr <= r_addr + 1'b1;
                    end
                    if (r_rvld && w_match) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                    if (!w_issue && !r_rvld) begin
                        r_prefix <= w_prefix_nx;
                        if (!(r_k < r_cnt)) begin
                            r_k <= r_k - r_cnt;
                        end
                        r_addr <= '0;
                        r_cnt  <= '0;
                        r_bit  <= r_bit - 1'b1;
                        if (r_bit == 6'd0) begin
                            o_quantile_ns <= w_prefix_nx;
                            r_state       <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== sv/heartbeat_gap_window_quantile.sv =====
// A sample, reset or unused-code request has its result registered as it leaves the
// two-entry request queue; up to one such request per cycle unless a result waits unread.
// A query first computes its index (a multiply by the reciprocal of 100), then runs a
// bitwise radix select over the n valid ring entries, one pass per gap bit.
// Reset (i_rst_n low, synchronous) clears the sample counters, the reference time and
// the queue; the gap ring itself is not cleared and needs no clearing pass.
`default_nettype none
module heartbeat_gap_window_quantile
    import hgwq_pkg::*;
#(
    parameter int WINDOW = 4096
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire  [1:0]  i_operation,
    input  wire  [63:0] i_time_ns,
    input  wire  [6:0]  i_percent,
    output logic        o_valid,
    input  wire         i_ready,
    output logic [63:0] o_gap_ns,
    output logic [63:0] o_quantile_ns,
    output logic [63:0] o_max_gap_ns,
    output logic [31:0] o_total_samples,
    output logic [12:0] o_window_samples
);
    // The front decodes each request (operation kind, percent clamped to 100)
    // and queues it. The back executes one request at a time, owns the ring
    // memory and the statistics, and holds the result in an output register,
    // so a waiting result stalls the front only once the queue is full.
    logic cvalid;
    logic cpop;
    t_cmd cmd;

    hgwq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_operation (i_operation),
        .i_time_ns   (i_time_ns),
        .i_percent   (i_percent),
        .o_cvalid    (cvalid),
        .o_cmd       (cmd),
        .i_cpop      (cpop)
    );

    // The query selects the k-th smallest gap one bit at a time from the top:
    // each pass counts the entries that share the known upper bits and have a
    // zero at the current bit, then fixes that bit by comparing against k.
    hgwq_back #(.WINDOW(WINDOW)) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cvalid         (cvalid),
        .i_cmd            (cmd),
        .o_cpop           (cpop),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_gap_ns         (o_gap_ns),
        .o_quantile_ns    (o_quantile_ns),
        .o_max_gap_ns     (o_max_gap_ns),
        .o_total_samples  (o_total_samples),
        .o_window_samples (o_window_samples)
    );
endmodule
`default_nettype wire
